FILE: rtl/multichannel_fade_controller_core_macros.svh
// assertion macros for the fade controller
`ifndef MULTICHANNEL_FADE_CONTROLLER_CORE_MACROS_SVH
`define MULTICHANNEL_FADE_CONTROLLER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define MFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/mfc_pkg.sv
// ---------------------------------------------------------------------------
// mfc_pkg
// types and constants of the multichannel fade controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mfc_pkg;
    localparam int CHANNELS = 13;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [16:0] FULL_ATT = 17'h10000;
    localparam int ENT_W = 28;   // fade_step (11) + attenuation (17)

    localparam logic [2:0] K_TICK = 3'd0;
    localparam logic [2:0] K_FIN = 3'd1;
    localparam logic [2:0] K_FHOLD = 3'd2;
    localparam logic [2:0] K_FSTOP = 3'd3;
    localparam logic [2:0] K_EVADE = 3'd4;
    localparam logic [2:0] K_START = 3'd5;
    localparam logic [2:0] K_VIEW = 3'd6;

    localparam logic [1:0] R_VDL = 2'd0;
    localparam logic [1:0] R_VDS = 2'd1;
    localparam logic [1:0] R_WDL = 2'd2;
    localparam logic [1:0] R_WDS = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] rate_sel;
        logic       song_running;
        logic       song_loaded;
        logic       voice_streaming;
        logic       enable;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  channel;
        logic [16:0] volume;
        logic        last;
        logic        accepted;
        logic        all_faded;
        logic        song_done;
        logic [8:0]  slowdown;
    } out_word_t;

    function automatic logic [9:0] fade_in_rate(input logic [1:0] s);
        unique case (s)
            2'd0: fade_in_rate = 10'd655;
            2'd1: fade_in_rate = 10'd218;
            default: fade_in_rate = 10'd131;
        endcase
    endfunction

    function automatic logic [10:0] fade_out_rate(input logic [1:0] s);
        unique case (s)
            2'd0: fade_out_rate = 11'd1310;
            2'd1: fade_out_rate = 11'd655;
            2'd2: fade_out_rate = 11'd218;
            default: fade_out_rate = 11'd131;
        endcase
    endfunction

    // clamped ramp toward level or zero
    function automatic logic [16:0] ramp(input logic [16:0] v, input logic up,
                                         input logic [16:0] level, input logic [11:0] step);
        logic [17:0] s;
        s = {1'b0, v} + {6'd0, step};
        if (up)
        begin
            if (v < level)
                ramp = (s > {1'b0, level}) ? level : s[16:0];
            else
                ramp = v;
        end
        else
            ramp = (v > {5'd0, step}) ? v - {5'd0, step} : 17'd0;
    endfunction
endpackage

FILE: rtl/multichannel_fade_controller_core.sv
// ---------------------------------------------------------------------------
// multichannel_fade_controller_core
// fade engine for the music channels, per-channel state in block ram
// ---------------------------------------------------------------------------
//  channel   direction  handshake       word
//  in        input      valid / stall   in_word_t command or tick
//  out       output     valid / stall   out_word_t per-channel volume
//  cfg       input      valid / ready   register index and data
//
// the channel state (fade step, attenuation) and the master volumes sit in
// two rams; every item is a walk over the channels. valid bits read as zero
// until a channel is written. a running tick takes three walks (any-step scan,
// update plus or-reduce, volume write) and a command one or two. the input
// stalls until the last walk of an item ends. a stall on the output holds
// the walk in place.
`timescale 1ns / 1ps
`include "multichannel_fade_controller_core_macros.svh"
module multichannel_fade_controller_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mfc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mfc_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data
);
    import mfc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;   // tick: look for any fade step
    localparam logic [2:0] S_UPD = 3'd2;    // update channel state
    localparam logic [2:0] S_EMIT = 3'd3;   // write volumes on running tick, emit words

    logic [2:0] state_reg, state_next;
    in_word_t cmd_reg;
    logic [CH_W:0] idx_reg;       // read address walker
    logic          rv_reg;        // read data valid this cycle
    logic [CH_W-1:0] ridx_reg;    // channel of read data

    // config registers
    logic [16:0] vdl_reg, wdl_reg;
    logic [11:0] vds_reg, wds_reg;

    // global state
    logic [CHANNELS-1:0] mask_reg, valid_reg, mvalid_reg;
    logic [9:0]  fin_reg;
    logic [1:0]  pend_reg;
    logic        stop_reg, hold_reg, view_reg, eva_reg;
    logic [16:0] vduck_reg, wduck_reg;
    logic [8:0]  evc_reg;
    logic        any_reg, orv_reg, acc_reg, done_reg;

    // ram ports
    logic we, mwe;
    logic [ENT_W-1:0] wdata, rdata;
    logic [16:0] mwdata, mrdata;
    logic [CH_W-1:0] raddr;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    mfc_ram #(.WIDTH(ENT_W), .DEPTH(CHANNELS)) u_state (
        .clk(clk), .we(we), .waddr(ridx_reg), .wdata(wdata),
        .raddr(raddr), .rdata(rdata));
    mfc_ram #(.WIDTH(17), .DEPTH(CHANNELS)) u_vol (
        .clk(clk), .we(mwe), .waddr(ridx_reg), .wdata(mwdata),
        .raddr(raddr), .rdata(mrdata));

    // decoded read data
    logic [10:0] stp;
    logic [16:0] att, mvol;
    logic        chmask;
    assign stp = valid_reg[ridx_reg] ? rdata[27:17] : 11'd0;
    assign att = valid_reg[ridx_reg] ? rdata[16:0] : 17'd0;
    assign mvol = mvalid_reg[ridx_reg] ? mrdata : 17'd0;
    assign chmask = mask_reg[ridx_reg];

    // decisions taken at accept
    logic full, acc_cmd, emit_ok, walk_adv, wlast;
    assign full = &mask_reg;
    always_comb
    begin
        unique case (in_data.kind)
            K_TICK: acc_cmd = 1'b1;
            K_FIN: acc_cmd = !stop_reg;
            K_FHOLD, K_EVADE: acc_cmd = in_data.song_loaded && !full;
            K_FSTOP: acc_cmd = in_data.song_loaded && (!full || fin_reg != 10'd0);
            K_START: acc_cmd = in_data.song_loaded;
            K_VIEW: acc_cmd = 1'b1;
            default: acc_cmd = 1'b0;
        endcase
    end

    // per-channel update during the update walk
    logic [10:0] nstp;
    logic [16:0] natt;
    logic [17:0] asum;
    logic        nmask;
    logic [16:0] duck, amax;
    always_comb
    begin
        nstp = stp;
        natt = att;
        nmask = chmask;
        asum = {1'b0, att} + {7'd0, stp};
        unique case (cmd_reg.kind)
            K_TICK:
            begin
                if (any_reg)
                begin
                    if (stp != 11'd0)
                    begin
                        if (asum >= {1'b0, FULL_ATT})
                        begin
                            natt = FULL_ATT;
                            nstp = 11'd0;
                            nmask = 1'b1;
                        end
                        else
                            natt = asum[16:0];
                    end
                end
                else if (fin_reg != 10'd0)
                    natt = ({7'd0, fin_reg} >= att) ? 17'd0 : att - {7'd0, fin_reg};
            end
            K_FIN:
            begin
                nstp = 11'd0;
                nmask = 1'b0;
            end
            K_FHOLD, K_FSTOP:
                if (!chmask)
                    nstp = fade_out_rate(cmd_reg.rate_sel);
            K_EVADE:
                if (ridx_reg == CH_W'(2) || ridx_reg == CH_W'(3))
                    nstp = 11'd43;
                else if (ridx_reg >= CH_W'(4) && !chmask)
                    nstp = 11'd81;
            K_START:
            begin
                nstp = 11'd0;
                nmask = 1'b0;
                // a deferred fade-in was armed at accept: start fully faded
                natt = (fin_reg != 10'd0) ? FULL_ATT : 17'd0;
            end
            default: ;
        endcase
    end

    assign duck = (vduck_reg <= wduck_reg) ? wduck_reg : vduck_reg;
    assign amax = (duck < att) ? att : duck;

    // walk progress: output stall holds emit
    assign emit_ok = (state_reg == S_EMIT) && rv_reg;
    assign walk_adv = !(emit_ok && out_stall);
    assign wlast = rv_reg && (ridx_reg == CH_W'(CHANNELS - 1));

    // a held word keeps reading its own entry
    assign raddr = walk_adv ? idx_reg[CH_W-1:0] : ridx_reg;

    assign we = (state_reg == S_UPD) && rv_reg;
    assign wdata = {nstp, natt};
    assign mwe = emit_ok && !out_stall && cmd_reg.kind == K_TICK
                 && cmd_reg.song_running;
    assign mwdata = (amax > FULL_ATT) ? 17'd0 : FULL_ATT - amax;

    // output word
    assign out_valid = emit_ok;
    always_comb
    begin
        out_data.channel = 4'(ridx_reg);
        out_data.volume = (cmd_reg.kind == K_TICK && cmd_reg.song_running) ? mwdata : mvol;
        out_data.last = (ridx_reg == CH_W'(CHANNELS - 1));
        out_data.accepted = acc_reg;
        out_data.all_faded = hold_reg;
        out_data.song_done = done_reg;
        out_data.slowdown = evc_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        priority case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (!acc_cmd || in_data.kind == K_VIEW)
                        state_next = S_EMIT;
                    else if (in_data.kind == K_TICK)
                        state_next = in_data.song_running ? S_SCAN : S_EMIT;
                    else if (in_data.kind == K_FIN && !in_data.song_running)
                        state_next = S_EMIT;
                    else
                        state_next = S_UPD;
                end
            S_SCAN, S_UPD:
                if (wlast)
                    state_next = (state_reg == S_SCAN) ? S_UPD : S_EMIT;
            default:
                if (wlast && walk_adv)
                    state_next = S_IDLE;
        endcase
    end

    // controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            rv_reg <= 1'b0;
            ridx_reg <= '0;
            vdl_reg <= 17'd24576;
            vds_reg <= 12'd245;
            wdl_reg <= 17'd20480;
            wds_reg <= 12'd204;
            mask_reg <= '0;
            valid_reg <= '0;
            mvalid_reg <= '0;
            fin_reg <= '0;
            pend_reg <= '0;
            stop_reg <= 1'b0;
            hold_reg <= 1'b0;
            view_reg <= 1'b0;
            eva_reg <= 1'b0;
            vduck_reg <= '0;
            wduck_reg <= '0;
            evc_reg <= '0;
            any_reg <= 1'b0;
            orv_reg <= 1'b0;
            acc_reg <= 1'b0;
            done_reg <= 1'b0;
            cmd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // config writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    R_VDL: vdl_reg <= cfg_data;
                    R_VDS: vds_reg <= cfg_data[11:0];
                    R_WDL: wdl_reg <= cfg_data;
                    default: wds_reg <= cfg_data[11:0];
                endcase
            end
            // address walk
            if (state_reg == S_IDLE)
            begin
                rv_reg <= 1'b0;
                idx_reg <= '0;
            end
            else if (walk_adv)
            begin
                if (wlast)
                begin
                    rv_reg <= 1'b0;
                    idx_reg <= '0;
                end
                else if (idx_reg < (CH_W+1)'(CHANNELS))
                begin
                    rv_reg <= 1'b1;
                    ridx_reg <= idx_reg[CH_W-1:0];
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                    rv_reg <= 1'b0;
            end
            // accept a command: global effects
            if (state_reg == S_IDLE && in_valid)
            begin
                cmd_reg <= in_data;
                acc_reg <= acc_cmd;
                done_reg <= 1'b0;
                any_reg <= 1'b0;
                orv_reg <= 1'b0;
                if (acc_cmd)
                begin
                    unique case (in_data.kind)
                        K_FIN:
                        begin
                            hold_reg <= 1'b0;
                            eva_reg <= 1'b0;
                            evc_reg <= '0;
                            if (!in_data.song_running)
                                pend_reg <= (in_data.rate_sel > 2'd2) ? 2'd3
                                            : in_data.rate_sel + 2'd1;
                            else
                            begin
                                fin_reg <= fade_in_rate(in_data.rate_sel);
                                mask_reg <= '0;
                            end
                        end
                        K_FHOLD: fin_reg <= '0;
                        K_FSTOP:
                        begin
                            fin_reg <= '0;
                            stop_reg <= 1'b1;
                        end
                        K_EVADE:
                        begin
                            fin_reg <= '0;
                            eva_reg <= 1'b1;
                        end
                        K_START:
                        begin
                            if (stop_reg)
                                mvalid_reg <= '0;
                            stop_reg <= 1'b0;
                            eva_reg <= 1'b0;
                            evc_reg <= '0;
                            fin_reg <= (pend_reg != 2'd0) ? fade_in_rate(pend_reg - 2'd1)
                                       : 10'd0;
                            pend_reg <= '0;
                            mask_reg <= '0;
                            hold_reg <= 1'b0;
                        end
                        K_VIEW: view_reg <= in_data.enable;
                        default: ;
                    endcase
                end
            end
            // scan for running fade step
            if (state_reg == S_SCAN && rv_reg && stp != 11'd0)
                any_reg <= 1'b1;
            // update walk: write back and fold
            if (we)
            begin
                valid_reg[ridx_reg] <= 1'b1;
                mask_reg[ridx_reg] <= nmask;
                if (natt != 17'd0)
                    orv_reg <= 1'b1;
            end
            // end of tick update: globals
            if (state_reg == S_UPD && wlast && cmd_reg.kind == K_TICK)
            begin
                if (any_reg)
                begin
                    if ((mask_reg | (CHANNELS'(nmask) << ridx_reg)) == '1)
                    begin
                        if (stop_reg)
                        begin
                            done_reg <= 1'b1;
                            stop_reg <= 1'b0;
                        end
                        else
                            hold_reg <= 1'b1;
                    end
                    else
                        hold_reg <= 1'b0;
                end
                else
                begin
                    vduck_reg <= ramp(vduck_reg, cmd_reg.voice_streaming, vdl_reg, vds_reg);
                    if (fin_reg != 10'd0 && !orv_reg && natt == 17'd0)
                        fin_reg <= '0;
                end
                wduck_reg <= ramp(wduck_reg, view_reg, wdl_reg, wds_reg);
                if (eva_reg)
                begin
                    if (evc_reg < 9'd256)
                        evc_reg <= evc_reg + 9'd1;
                end
                else
                    evc_reg <= (evc_reg <= 9'd16) ? 9'd0 : evc_reg - 9'd16;
            end
            if (mwe)
                mvalid_reg[ridx_reg] <= 1'b1;
        end
    end

    // assertions
    `MFC_ASSERT_IMP(a_no_out_idle, state_reg == S_IDLE, !out_valid)
    `MFC_ASSERT_IMP(a_cfg_idle, cfg_valid && cfg_ready, in_stall == 1'b0)
    `MFC_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_data.last,
                     state_reg == S_IDLE)
endmodule

FILE: rtl/mfc_ram.sv
// ---------------------------------------------------------------------------
// mfc_ram
// generic single-port-write, registered-read ram
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: verif/fade_checker.sv
// ---------------------------------------------------------------------------
// fade_checker
// watches the command, volume and register channels of the fade controller,
// predicts the per-channel volume words and compares them in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fade_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  mfc_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  mfc_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_words
);
    import mfc_pkg::*;

    localparam logic [CHANNELS-1:0] ALL_FADED = {CHANNELS{1'b1}};

    // register copies
    logic [16:0] voice_level;
    logic [11:0] voice_step;
    logic [16:0] view_level;
    logic [11:0] view_step;

    // channel state copies
    logic [10:0] step_q [CHANNELS];
    logic [16:0] att_q [CHANNELS];
    logic [16:0] vol_q [CHANNELS];
    logic [CHANNELS-1:0] faded;
    logic [9:0]  fin_step;
    logic [1:0]  deferred_fin;
    logic        stop_armed, holding, view_on, evading;
    logic [16:0] voice_duck, view_duck;
    logic [8:0]  evade_cnt;

    out_word_t volume_words[$];

    assign pending_words = volume_words.size();

    function automatic logic [16:0] ramp_to(logic [16:0] v, logic up, logic [16:0] lvl,
                                            logic [11:0] st);
        logic [17:0] s;
        s = {1'b0, v} + {6'd0, st};
        if (up)
            return (v < lvl) ? ((s > {1'b0, lvl}) ? lvl : s[16:0]) : v;
        return (v > {5'd0, st}) ? v - {5'd0, st} : 17'd0;
    endfunction

    function automatic logic [9:0] fin_rate(logic [1:0] s);
        return (s == 2'd0) ? 10'd655 : (s == 2'd1) ? 10'd218 : 10'd131;
    endfunction

    function automatic logic [10:0] fout_rate(logic [1:0] s);
        case (s)
            2'd0: return 11'd1310;
            2'd1: return 11'd655;
            2'd2: return 11'd218;
            default: return 11'd131;
        endcase
    endfunction

    task automatic clear_state();
        for (int i = 0; i < CHANNELS; i++)
        begin
            step_q[i] = '0;
            att_q[i] = '0;
            vol_q[i] = '0;
        end
        faded = '0;
        fin_step = '0;
        deferred_fin = '0;
        stop_armed = 0;
        holding = 0;
        view_on = 0;
        evading = 0;
        voice_duck = '0;
        view_duck = '0;
        evade_cnt = '0;
        voice_level = 17'd24576;
        voice_step = 12'd245;
        view_level = 17'd20480;
        view_step = 12'd204;
    endtask

    task automatic start_fade_out(logic [10:0] r);
        for (int i = 0; i < CHANNELS; i++)
            if (!faded[i])
                step_q[i] = r;
        fin_step = '0;
    endtask

    task automatic arm_fade_in(logic [1:0] s);
        fin_step = fin_rate(s);
        for (int i = 0; i < CHANNELS; i++)
            step_q[i] = '0;
        faded = '0;
    endtask

    // one audio frame step, returns the stop-finished flag
    function automatic logic frame_tick(logic streaming);
        logic any, done;
        logic [17:0] sum;
        logic [16:0] orv, duck, a;
        any = 0;
        done = 0;
        for (int i = 0; i < CHANNELS; i++)
            if (step_q[i] != 0)
                any = 1;
        if (any)
        begin
            for (int i = 0; i < CHANNELS; i++)
                if (step_q[i] != 0)
                begin
                    sum = {1'b0, att_q[i]} + {7'd0, step_q[i]};
                    if (sum >= {1'b0, FULL_ATT})
                    begin
                        faded[i] = 1;
                        att_q[i] = FULL_ATT;
                        step_q[i] = '0;
                    end
                    else
                        att_q[i] = sum[16:0];
                end
            if (faded == ALL_FADED)
            begin
                if (stop_armed)
                begin
                    done = 1;
                    stop_armed = 0;
                end
                else
                    holding = 1;
            end
            else
                holding = 0;
        end
        else
        begin
            voice_duck = ramp_to(voice_duck, streaming, voice_level, voice_step);
            if (fin_step != 0)
            begin
                orv = '0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    att_q[i] = ({7'd0, fin_step} >= att_q[i]) ? 17'd0
                               : att_q[i] - {7'd0, fin_step};
                    orv |= att_q[i];
                end
                if (orv == 0)
                    fin_step = '0;
            end
        end
        view_duck = ramp_to(view_duck, view_on, view_level, view_step);
        duck = (voice_duck <= view_duck) ? view_duck : voice_duck;
        for (int i = 0; i < CHANNELS; i++)
        begin
            a = (duck < att_q[i]) ? att_q[i] : duck;
            vol_q[i] = (a > FULL_ATT) ? 17'd0 : FULL_ATT - a;
        end
        if (evading)
        begin
            if (evade_cnt < 9'd256)
                evade_cnt++;
        end
        else if (evade_cnt != 0)
            evade_cnt = (evade_cnt <= 9'd16) ? 9'd0 : evade_cnt - 9'd16;
        return done;
    endfunction

    task automatic predict_command(in_word_t w);
        logic acc, done;
        out_word_t o;
        acc = 0;
        done = 0;
        case (w.kind)
            K_TICK:
            begin
                acc = 1;
                if (w.song_running)
                    done = frame_tick(w.voice_streaming);
            end
            K_FIN:
                if (!stop_armed)
                begin
                    holding = 0;
                    if (!w.song_running)
                        deferred_fin = 2'd1 + ((w.rate_sel > 2'd2) ? 2'd2 : w.rate_sel);
                    else
                        arm_fade_in(w.rate_sel);
                    evading = 0;
                    evade_cnt = '0;
                    acc = 1;
                end
            K_FHOLD:
                if (w.song_loaded && faded != ALL_FADED)
                begin
                    start_fade_out(fout_rate(w.rate_sel));
                    acc = 1;
                end
            K_FSTOP:
                if (w.song_loaded && (faded != ALL_FADED || fin_step != 0))
                begin
                    start_fade_out(fout_rate(w.rate_sel));
                    stop_armed = 1;
                    acc = 1;
                end
            K_EVADE:
                if (w.song_loaded && faded != ALL_FADED)
                begin
                    for (int i = 2; i < CHANNELS; i++)
                        if (i < 4)
                            step_q[i] = 11'd43;
                        else if (!faded[i])
                            step_q[i] = 11'd81;
                    fin_step = '0;
                    evading = 1;
                    acc = 1;
                end
            K_START:
                if (w.song_loaded)
                begin
                    if (stop_armed)
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            step_q[i] = '0;
                            att_q[i] = '0;
                            vol_q[i] = '0;
                        end
                    stop_armed = 0;
                    evading = 0;
                    evade_cnt = '0;
                    if (deferred_fin == 0)
                    begin
                        fin_step = '0;
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            step_q[i] = '0;
                            att_q[i] = '0;
                        end
                    end
                    else
                    begin
                        arm_fade_in(deferred_fin - 2'd1);
                        for (int i = 0; i < CHANNELS; i++)
                            att_q[i] = FULL_ATT;
                        deferred_fin = '0;
                    end
                    faded = '0;
                    holding = 0;
                    acc = 1;
                end
            K_VIEW:
            begin
                view_on = w.enable;
                acc = 1;
            end
            default: ;
        endcase
        for (int i = 0; i < CHANNELS; i++)
        begin
            o.channel = 4'(i);
            o.volume = vol_q[i];
            o.last = (i == CHANNELS - 1);
            o.accepted = acc;
            o.all_faded = holding;
            o.song_done = done;
            o.slowdown = evade_cnt;
            volume_words.push_back(o);
        end
    endtask

    // watch the channels and compare
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            clear_state();
            volume_words.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    R_VDL: voice_level = cfg_data;
                    R_VDS: voice_step = cfg_data[11:0];
                    R_WDL: view_level = cfg_data;
                    default: view_step = cfg_data[11:0];
                endcase
            if (in_valid && !in_stall)
                predict_command(in_data);
            if (out_valid && !out_stall)
            begin
                if (volume_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = volume_words.pop_front();
                    if (out_data !== e)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// drives commands, ticks and register writes into the fade controller with
// random idling on both sides; a checker beside the block scores the words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import mfc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fail_count;
    int          pending_words;
    int          cycle_count;
    logic        calm;

    multichannel_fade_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fade_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send_word(in_word_t w);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic send_cmd(logic [2:0] k, logic [1:0] r, logic run, logic ld, logic vs,
                            logic en);
        in_word_t w;
        w.kind = k;
        w.rate_sel = r;
        w.song_running = run;
        w.song_loaded = ld;
        w.voice_streaming = vs;
        w.enable = en;
        send_word(w);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_words != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // random song life: mostly running ticks with fades mixed in
    task automatic random_song(int count);
        int p;
        logic [2:0] k;
        send_cmd(K_START, 2'($urandom), 1'($urandom), 1, 1'($urandom), 1'($urandom));
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 55) k = K_TICK;
            else if (p < 63) k = K_FIN;
            else if (p < 71) k = K_FHOLD;
            else if (p < 77) k = K_FSTOP;
            else if (p < 83) k = K_EVADE;
            else if (p < 88) k = K_START;
            else if (p < 95) k = K_VIEW;
            else k = 3'($urandom_range(0, 7));
            send_cmd(k, 2'($urandom), ($urandom_range(0, 9) != 0),
                     ($urandom_range(0, 7) != 0), 1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 0;
        calm = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = R_VDL;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: commands on an idle block, then fades to the end
        send_cmd(K_TICK, 0, 0, 0, 0, 0);
        send_cmd(K_FHOLD, 0, 0, 0, 0, 0);
        send_cmd(K_EVADE, 0, 0, 0, 0, 0);
        send_cmd(K_START, 0, 0, 0, 0, 0);
        send_cmd(3'd7, 3, 1, 1, 1, 1);
        send_cmd(K_FIN, 3, 0, 1, 0, 0);
        send_cmd(K_START, 0, 1, 1, 0, 0);
        repeat (3) send_cmd(K_TICK, 0, 1, 1, 1, 0);
        send_cmd(K_VIEW, 0, 1, 1, 0, 1);
        send_cmd(K_FHOLD, 0, 1, 1, 0, 0);
        repeat (52) send_cmd(K_TICK, 0, 1, 1, 1, 0);
        send_cmd(K_FHOLD, 0, 1, 1, 0, 0);
        send_cmd(K_FSTOP, 0, 1, 1, 0, 0);
        send_cmd(K_FIN, 0, 1, 1, 0, 0);
        send_cmd(K_EVADE, 0, 1, 1, 0, 0);
        send_cmd(K_START, 1, 1, 1, 0, 0);
        send_cmd(K_FSTOP, 0, 1, 1, 0, 0);
        send_cmd(K_FIN, 0, 1, 1, 0, 0);
        repeat (52) send_cmd(K_TICK, 0, 1, 1, 0, 0);
        send_cmd(K_START, 2, 1, 1, 0, 0);
        send_cmd(K_EVADE, 0, 1, 1, 0, 0);
        repeat (8) send_cmd(K_TICK, 0, 1, 1, 0, 1);
        send_cmd(K_FIN, 1, 1, 1, 0, 0);
        drain();

        // register extremes and random settings between phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(R_VDL, 17'h10000);
                    write_reg(R_VDS, 17'hfff);
                    write_reg(R_WDL, 17'd0);
                    write_reg(R_WDS, 17'd0);
                end
                1:
                begin
                    write_reg(R_VDL, 17'd0);
                    write_reg(R_VDS, 17'd0);
                    write_reg(R_WDL, 17'h10000);
                    write_reg(R_WDS, 17'hfff);
                end
                default:
                begin
                    write_reg(R_VDL, 17'($urandom_range(0, 65536)));
                    write_reg(R_VDS, 17'($urandom_range(0, 4095)));
                    write_reg(R_WDL, 17'($urandom_range(0, 65536)));
                    write_reg(R_WDS, 17'($urandom_range(0, 4095)));
                end
            endcase
            if (ph == 5)
                calm = 1;
            random_song(14);
            drain();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
